/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL; they compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define SDPP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true outside reset.
`define SDPP_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define SDPP_ASSERT(lbl, clk, rst, prop, msg)
`define SDPP_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

/* rtl/sdpp_pkg.sv */
package sdpp_pkg;

  localparam int NUM_WIDTH_DEF = 32;
  localparam int OUT_W         = 56;

  // Line kinds
  typedef enum logic [3:0] {
    K_OTHER = 4'd0, K_V = 4'd1, K_O = 4'd2, K_S = 4'd3, K_I = 4'd4,
    K_C = 4'd5, K_T = 4'd6, K_M = 4'd7, K_A = 4'd8
  } kind_t;

  // Line parser states, one-hot
  typedef enum logic [25:0] {
    S_LINE    = 26'(1 << 0),  S_EQ      = 26'(1 << 1),  S_SKIP    = 26'(1 << 2),
    S_SP      = 26'(1 << 3),  S_TEXT    = 26'(1 << 4),  S_VER     = 26'(1 << 5),
    S_O_USER  = 26'(1 << 6),  S_O_ID    = 26'(1 << 7),  S_O_SVER  = 26'(1 << 8),
    S_O_NET   = 26'(1 << 9),  S_O_ATYPE = 26'(1 << 10), S_O_ADDR  = 26'(1 << 11),
    S_C_NET   = 26'(1 << 12), S_C_ATYPE = 26'(1 << 13), S_C_ADDR  = 26'(1 << 14),
    S_C_SLASH = 26'(1 << 15), S_C_END   = 26'(1 << 16), S_T_START = 26'(1 << 17),
    S_T_END   = 26'(1 << 18), S_M_MEDIA = 26'(1 << 19), S_M_PORT  = 26'(1 << 20),
    S_M_PNUM  = 26'(1 << 21), S_M_PROTO = 26'(1 << 22), S_M_FMT   = 26'(1 << 23),
    S_A_NAME  = 26'(1 << 24), S_A_VAL   = 26'(1 << 25)
  } state_t;

  // Characters
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // Text field codes
  localparam logic [4:0] TF_NONE = 5'd0,  TF_SESS_NAME = 5'd1, TF_SESS_INFO = 5'd2;
  localparam logic [4:0] TF_O_USER = 5'd3, TF_O_ID = 5'd4, TF_O_NET = 5'd5;
  localparam logic [4:0] TF_O_ATYPE = 5'd6, TF_O_ADDR = 5'd7, TF_C_NET = 5'd8;
  localparam logic [4:0] TF_C_ATYPE = 5'd9, TF_C_ADDR = 5'd10, TF_M_MEDIA = 5'd11;
  localparam logic [4:0] TF_M_PROTO = 5'd12, TF_A_NAME = 5'd13, TF_A_VAL = 5'd14;

  // Number field codes
  localparam logic [4:0] NF_NONE = 5'd0, NF_VERSION = 5'd1, NF_O_SVER = 5'd2;
  localparam logic [4:0] NF_C_TTL = 5'd3, NF_T_START = 5'd4, NF_T_END = 5'd5;
  localparam logic [4:0] NF_M_PORT = 5'd6, NF_M_PNUM = 5'd7, NF_FMT_RUN = 5'd8;
  localparam logic [4:0] NF_FMT_DONE = 5'd9;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0, ERR_ORIGIN = 2'd1, ERR_TIME = 2'd2;
  localparam logic [1:0] ERR_ABORT = 2'd3;

  // Control state carried between beats
  typedef struct packed {
    kind_t  kind;
    state_t state;
    state_t resume;
    logic   media_seen;
    logic   aborted;
  } ctrl_t;

  // One result beat
  typedef struct packed {
    logic [4:0]  text_field;
    logic [7:0]  text_char;
    logic [4:0]  number_field;
    logic [31:0] number_value;
    logic        media_start;
    logic        attr_in_media;
    logic [1:0]  error_code;
  } res_t;

  function automatic kind_t kind_of(input logic [7:0] b);
    kind_t k;
    case (b)
      8'h76:   k = K_V;
      8'h6F:   k = K_O;
      8'h73:   k = K_S;
      8'h69:   k = K_I;
      8'h63:   k = K_C;
      8'h74:   k = K_T;
      8'h6D:   k = K_M;
      8'h61:   k = K_A;
      default: k = K_OTHER;
    endcase
    return k;
  endfunction

endpackage

/* rtl/sdpp_step.sv */
// Next-state and result logic for one text byte.
module sdpp_step #(
  parameter int NUM_WIDTH = sdpp_pkg::NUM_WIDTH_DEF
) (
  input  logic [7:0]           text_byte_in,
  input  logic                 first_of_buffer,
  input  sdpp_pkg::ctrl_t      cur,
  input  logic [NUM_WIDTH-1:0] acc,
  output sdpp_pkg::ctrl_t      nxt,
  output logic [NUM_WIDTH-1:0] acc_next,
  output sdpp_pkg::res_t       res
);
  import sdpp_pkg::*;

  ctrl_t                c0;
  logic [NUM_WIDTH-1:0] a0;
  logic [NUM_WIDTH-1:0] a_dig;
  logic [NUM_WIDTH+31:0] ext;
  logic                 sp, dig, eol;
  state_t               eff;
  logic [4:0]           nf;
  logic [NUM_WIDTH-1:0] nv;

  // Start-of-description restart
  always_comb begin
    c0 = cur;
    a0 = acc;
    if (first_of_buffer) begin
      c0.aborted    = 1'b0;
      c0.media_seen = 1'b0;
      c0.state      = S_LINE;
      c0.kind       = K_OTHER;
      c0.resume     = S_SKIP;
      a0            = '0;
    end
  end

  assign sp    = (text_byte_in == CH_SPACE);
  assign dig   = (text_byte_in >= CH_0) && (text_byte_in <= CH_9);
  assign eol   = (text_byte_in == CH_CR) || (text_byte_in == CH_LF);
  assign a_dig = (a0 << 3) + (a0 << 1) + NUM_WIDTH'(text_byte_in[3:0]);
  // A non-space after a skipped run is reprocessed in the resume state
  assign eff   = (c0.state == S_SP && !sp) ? c0.resume : c0.state;

  always_comb begin
    nxt = c0;
    acc_next = a0;
    res = '0;
    nf = NF_NONE;
    nv = '0;
    if (c0.aborted) begin
      res.error_code = ERR_ABORT;
    end else if (eol) begin
      if (c0.state != S_LINE) begin
        if (c0.kind == K_C && c0.state == S_C_SLASH) begin
          nf = NF_C_TTL; nv = a0;
        end
        if (c0.kind == K_M && c0.state == S_M_FMT) begin
          nf = NF_FMT_DONE; nv = a0;
        end
        if (c0.kind == K_T && c0.state != S_T_END) res.error_code = ERR_TIME;
        nxt.state = S_LINE;
      end
    end else if (c0.state == S_LINE) begin
      nxt.kind  = kind_of(text_byte_in);
      nxt.state = S_EQ;
      if (kind_of(text_byte_in) == K_M) begin
        nxt.media_seen  = 1'b1;
        res.media_start = 1'b1;
      end
    end else begin
      nxt.state = eff;
      case (eff)
        S_EQ: begin
          if (text_byte_in == CH_EQ) begin
            acc_next = '0;
            case (c0.kind)
              K_V:     nxt.state = S_VER;
              K_O:     nxt.state = S_O_USER;
              K_C:     nxt.state = S_C_NET;
              K_T:     nxt.state = S_T_START;
              K_M:     nxt.state = S_M_MEDIA;
              K_A:     nxt.state = S_A_NAME;
              default: nxt.state = S_TEXT;
            endcase
          end else if (c0.kind == K_V || c0.kind == K_C) begin
            nxt.aborted = 1'b1;
            res.error_code = ERR_ABORT;
          end else begin
            nxt.state = S_SKIP;
          end
        end
        S_SKIP, S_SP: ;
        S_TEXT: begin
          if (c0.kind == K_S) res.text_field = TF_SESS_NAME;
          else if (c0.kind == K_I) res.text_field = TF_SESS_INFO;
        end
        S_VER: if (dig) begin acc_next = a_dig; nf = NF_VERSION; nv = a_dig; end
        S_O_USER: begin
          if (sp) begin nxt.state = S_SP; nxt.resume = S_O_ID; end
          else res.text_field = TF_O_USER;
        end
        S_O_ID: begin
          if (sp) begin nxt.state = S_SP; nxt.resume = S_O_SVER; acc_next = '0; end
          else res.text_field = TF_O_ID;
        end
        S_O_SVER: begin
          if (dig) begin acc_next = a_dig; nf = NF_O_SVER; nv = a_dig; end
          else if (sp) begin nxt.state = S_SP; nxt.resume = S_O_NET; end
          else begin res.error_code = ERR_ORIGIN; nxt.state = S_SKIP; end
        end
        S_O_NET: begin
          if (sp) begin nxt.state = S_SP; nxt.resume = S_O_ATYPE; end
          else res.text_field = TF_O_NET;
        end
        S_O_ATYPE: begin
          if (sp) begin nxt.state = S_SP; nxt.resume = S_O_ADDR; end
          else res.text_field = TF_O_ATYPE;
        end
        S_O_ADDR: begin
          if (sp) begin nxt.state = S_SP; nxt.resume = S_SKIP; end
          else res.text_field = TF_O_ADDR;
        end
        S_C_NET: if (sp) nxt.state = S_C_ATYPE; else res.text_field = TF_C_NET;
        S_C_ATYPE: if (sp) nxt.state = S_C_ADDR; else res.text_field = TF_C_ATYPE;
        S_C_ADDR: begin
          if (text_byte_in == CH_SLASH) begin nxt.state = S_C_SLASH; acc_next = '0; end
          else if (sp) nxt.state = S_C_END;
          else res.text_field = TF_C_ADDR;
        end
        S_C_SLASH: if (dig) acc_next = a_dig;
        S_C_END: begin
          if (!sp) begin nxt.aborted = 1'b1; res.error_code = ERR_ABORT; end
        end
        S_T_START: begin
          if (dig) begin acc_next = a_dig; nf = NF_T_START; nv = a_dig; end
          else if (sp) begin nxt.state = S_T_END; acc_next = '0; end
          else begin res.error_code = ERR_TIME; nxt.state = S_SKIP; end
        end
        S_T_END: begin
          if (dig) begin acc_next = a_dig; nf = NF_T_END; nv = a_dig; end
          else if (sp) begin nxt.state = S_SP; nxt.resume = S_SKIP; end
        end
        S_M_MEDIA: begin
          if (sp) begin nxt.state = S_SP; nxt.resume = S_M_PORT; acc_next = '0; end
          else res.text_field = TF_M_MEDIA;
        end
        S_M_PORT: begin
          if (dig) begin acc_next = a_dig; nf = NF_M_PORT; nv = a_dig; end
          else if (text_byte_in == CH_SLASH) begin nxt.state = S_M_PNUM; acc_next = '0; end
          else if (sp) begin nxt.state = S_SP; nxt.resume = S_M_PROTO; end
        end
        S_M_PNUM: begin
          if (dig) begin acc_next = a_dig; nf = NF_M_PNUM; nv = a_dig; end
          else if (sp) begin nxt.state = S_SP; nxt.resume = S_M_PROTO; end
        end
        S_M_PROTO: begin
          if (sp) begin nxt.state = S_SP; nxt.resume = S_M_FMT; acc_next = '0; end
          else res.text_field = TF_M_PROTO;
        end
        S_M_FMT: begin
          if (dig) begin acc_next = a_dig; nf = NF_FMT_RUN; nv = a_dig; end
          else if (sp) begin
            nf = NF_FMT_DONE; nv = a0; acc_next = '0;
            nxt.state = S_SP; nxt.resume = S_M_FMT;
          end
        end
        S_A_NAME: begin
          if (text_byte_in == CH_COLON) nxt.state = S_A_VAL;
          else res.text_field = TF_A_NAME;
        end
        S_A_VAL: res.text_field = TF_A_VAL;
        default: nxt.state = S_SKIP;
      endcase
    end
    if (res.text_field != TF_NONE) res.text_char = text_byte_in;
    res.number_field  = nf;
    // Low 32 bits of the reported value, zero-extended for narrow accumulators
    ext = {32'b0, nv};
    res.number_value  = ext[31:0];
    res.attr_in_media = (nxt.kind == K_A) && nxt.media_seen && !nxt.aborted;
  end

endmodule

/* rtl/sdp_line_field_parser_top.sv */
// SDP line field parser. Takes one text byte per beat and returns one tagged
// result beat per byte: an item may be accepted every clock, with each result
// beat held in the single result register, and the input stays ready while that
// register is empty or being drained. Line state and the decimal accumulator
// advance once per accepted byte; tuser marks the first byte of a new
// description and restarts parsing.
module sdp_line_field_parser_top #(
  parameter int NUM_WIDTH = sdpp_pkg::NUM_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte_in
  input  logic       s_tuser,   // [0] first_of_buffer
  output logic       m_tvalid,
  input  logic       m_tready,
  // [4:0] text_field, [12:5] text_char, [17:13] number_field,
  // [49:18] number_value, [50] media_start, [51] attr_in_media,
  // [53:52] error_code, [55:54] zero
  output logic [sdpp_pkg::OUT_W-1:0] m_tdata
);
  import sdpp_pkg::*;
  `include "assert_macros.svh"

  ctrl_t                ctrl, ctrl_next;
  logic [NUM_WIDTH-1:0] acc, acc_next;
  res_t                 res, res_q;
  logic                 accept;
  logic                 res_has_field, abort_beat, ms_beat;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  sdpp_step #(.NUM_WIDTH(NUM_WIDTH)) u_step (
    .text_byte_in    (s_tdata),
    .first_of_buffer (s_tuser),
    .cur             (ctrl),
    .acc             (acc),
    .nxt             (ctrl_next),
    .acc_next        (acc_next),
    .res             (res)
  );

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.kind       <= K_OTHER;
      ctrl.state      <= S_LINE;
      ctrl.resume     <= S_SKIP;
      ctrl.media_seen <= 1'b0;
      ctrl.aborted    <= 1'b0;
      acc             <= '0;
    end else if (accept) begin
      ctrl <= ctrl_next;
      acc  <= acc_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_q <= res;
  end

  assign m_tdata = {2'b00, res_q.error_code, res_q.attr_in_media, res_q.media_start,
                    res_q.number_value, res_q.number_field, res_q.text_char,
                    res_q.text_field};

  // Beat classes for the checks below
  assign res_has_field = (res_q.text_field != TF_NONE) || (res_q.number_field != NF_NONE);
  assign abort_beat    = m_tvalid && (res_q.error_code == ERR_ABORT);
  assign ms_beat       = m_tvalid && res_q.media_start;

  `SDPP_NEVER(a_abort_quiet, clk, rst, abort_beat && res_has_field, "aborted beat carries a field")
  `SDPP_ASSERT(a_abort_sticky, clk, rst, accept && ctrl.aborted && !s_tuser |=> abort_beat, "abort not held")
  `SDPP_NEVER(a_media_start_clean, clk, rst, ms_beat && res_has_field, "media start beat has a field")

endmodule
